// ----- rtl/fmeg_pkg.sv -----
// Shared types, constants and lookup functions for the footswitch MIDI event generator.
// Used by every RTL module of the block and by the port checker; depends on nothing.
package fmeg_pkg;

  localparam int TIME_BITS_DEF = 32;
  localparam int NOW_W         = 32;
  localparam int CFG_IDX_W     = 3;
  localparam int CFG_DATA_W    = 16;

  localparam logic [7:0] CC_STATUS = 8'hB0;
  localparam logic [7:0] PC_STATUS = 8'hC0;
  localparam logic [6:0] CC_FULL   = 7'd127;

  typedef enum logic [1:0] {
    CMD_CC  = 2'd0,
    CMD_PC  = 2'd1,
    CMD_MMC = 2'd2,
    CMD_BAD = 2'd3
  } cmd_type_t;

  typedef enum logic [2:0] {
    SW_TOGGLE_OFF    = 3'd0,
    SW_TOGGLE_ON     = 3'd1,
    SW_MOMENTARY_OFF = 3'd2,
    SW_MOMENTARY_ON  = 3'd3,
    SW_SINGLE_OFF    = 3'd4,
    SW_SINGLE_ON     = 3'd5
  } sw_mode_t;

  typedef enum logic [1:0] {
    KIND_CC  = 2'd0,
    KIND_PC  = 2'd1,
    KIND_MMC = 2'd2
  } msg_kind_t;

  typedef enum logic [2:0] {
    REG_COMMAND_TYPE   = 3'd0,
    REG_COMMAND_NUMBER = 3'd1,
    REG_SWITCH_MODE    = 3'd2,
    REG_MIDI_CHANNEL   = 3'd3,
    REG_DEBOUNCE_MS    = 3'd4,
    REG_FLASH_MS       = 3'd5
  } reg_index_t;

  // Machine-control command codes.
  localparam logic [6:0] MMC_NONE   = 7'h00;
  localparam logic [6:0] MMC_STOP   = 7'h01;
  localparam logic [6:0] MMC_PLAY   = 7'h02;
  localparam logic [6:0] MMC_FFWD   = 7'h04;
  localparam logic [6:0] MMC_REWIND = 7'h05;
  localparam logic [6:0] MMC_RECORD = 7'h06;
  localparam logic [6:0] MMC_PAUSE  = 7'h09;

  typedef struct packed {
    cmd_type_t   command_type;
    logic [6:0]  command_number;
    sw_mode_t    switch_mode;
    logic [3:0]  midi_channel;
    logic [15:0] debounce_ms;
    logic [15:0] flash_ms;
  } fmeg_cfg_t;

  typedef struct packed {
    logic prev_level;
    logic toggle_value;
    logic led_level;
  } fmeg_flags_t;

  typedef struct packed {
    logic       led_on;
    logic       send_valid;
    logic [1:0] message_kind;
    logic [7:0] status_byte;
    logic [6:0] data_first;
    logic [6:0] data_second;
  } fmeg_result_t;

  function automatic logic [6:0] mmc_on_code(input logic [2:0] sel);
    logic [6:0] code;
    case (sel)
      3'd0:    code = MMC_PLAY;
      3'd1:    code = MMC_PLAY;
      3'd2:    code = MMC_STOP;
      3'd3:    code = MMC_RECORD;
      3'd4:    code = MMC_RECORD;
      3'd5:    code = MMC_PAUSE;
      3'd6:    code = MMC_FFWD;
      3'd7:    code = MMC_REWIND;
      default: code = MMC_PLAY;
    endcase
    return code;
  endfunction

  function automatic logic [6:0] mmc_off_code(input logic [2:0] sel);
    logic [6:0] code;
    case (sel)
      3'd1:    code = MMC_STOP;
      3'd4:    code = MMC_STOP;
      default: code = MMC_NONE;
    endcase
    return code;
  endfunction

  function automatic logic mmc_is_toggle(input logic [2:0] sel);
    return (sel == 3'd1) || (sel == 3'd4);
  endfunction

endpackage

// ----- rtl/footswitch_midi_event_generator.sv -----
// Footswitch MIDI event generator, top level: sample register, switch state,
// configuration registers and result register; depends on fmeg_pkg and fmeg_step.
//
// Takes one pin sample with its millisecond timestamp per clock unless stalled
// and gives one result per sample: the LED level and, on an accepted switch edge,
// one MIDI message. A sample is held in an input register, evaluated against the
// switch state combinationally, and its result is captured in the result register;
// throughput is one sample per clock without a stall, limited only by the state
// update loop, which closes within the evaluation. Configuration writes take effect
// at once; writing switch_mode presets the LED and, in toggle modes, the toggle bit.
module footswitch_midi_event_generator #(
  parameter int TIME_BITS = fmeg_pkg::TIME_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic                             in_pin_level,
  input  logic [fmeg_pkg::NOW_W-1:0]       in_now_ms,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic                             out_led_on,
  output logic                             out_send_valid,
  output logic [1:0]                       out_message_kind,
  output logic [7:0]                       out_status_byte,
  output logic [6:0]                       out_data_first,
  output logic [6:0]                       out_data_second,
  input  logic                             cfg_wr_en,
  input  logic [fmeg_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [fmeg_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
  import fmeg_pkg::*;

  fmeg_cfg_t            cfg_r;
  fmeg_flags_t          flags_r;
  fmeg_flags_t          flags_nxt;
  fmeg_flags_t          flags_step;
  logic [TIME_BITS-1:0] dstamp_r;
  logic [TIME_BITS-1:0] dstamp_nxt;
  logic [TIME_BITS-1:0] dstamp_step;
  logic [TIME_BITS-1:0] fstamp_r;
  logic [TIME_BITS-1:0] fstamp_nxt;
  logic [TIME_BITS-1:0] fstamp_step;
  logic                 s1_valid_r;
  logic                 s1_pin_r;
  logic [NOW_W-1:0]     s1_now_r;
  logic                 out_valid_r;
  fmeg_result_t         res_r;
  fmeg_result_t         res_step;
  logic                 out_free;
  logic                 advance;
  logic                 in_xfer;

  assign out_free = !out_valid_r || out_ready;
  assign advance  = s1_valid_r && out_free;
  assign in_ready = !s1_valid_r || out_free;
  assign in_xfer  = in_valid && in_ready;

  fmeg_step #(.TIME_BITS(TIME_BITS)) u_step (
    .cfg                (cfg_r),
    .pin_level          (s1_pin_r),
    .now                (TIME_BITS'(s1_now_r)),
    .flags              (flags_r),
    .debounce_stamp     (dstamp_r),
    .flash_stamp        (fstamp_r),
    .flags_nxt          (flags_step),
    .debounce_stamp_nxt (dstamp_step),
    .flash_stamp_nxt    (fstamp_step),
    .result             (res_step)
  );

  // State follows the evaluated sample; a switch_mode write overrides the LED and toggle bits.
  always_comb begin
    flags_nxt  = flags_r;
    dstamp_nxt = dstamp_r;
    fstamp_nxt = fstamp_r;
    if (advance) begin
      flags_nxt  = flags_step;
      dstamp_nxt = dstamp_step;
      fstamp_nxt = fstamp_step;
    end
    if (cfg_wr_en && (cfg_index == REG_SWITCH_MODE)) begin
      case (cfg_wdata[2:0])
        SW_TOGGLE_ON: begin
          flags_nxt.toggle_value = 1'b1;
          flags_nxt.led_level    = 1'b1;
        end
        SW_MOMENTARY_OFF: flags_nxt.led_level = 1'b1;
        SW_MOMENTARY_ON,
        SW_SINGLE_OFF,
        SW_SINGLE_ON:     flags_nxt.led_level = 1'b0;
        default: begin
          flags_nxt.toggle_value = 1'b0;
          flags_nxt.led_level    = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.command_type   <= CMD_CC;
      cfg_r.command_number <= 7'd0;
      cfg_r.switch_mode    <= SW_TOGGLE_OFF;
      cfg_r.midi_channel   <= 4'd0;
      cfg_r.debounce_ms    <= 16'd50;
      cfg_r.flash_ms       <= 16'd200;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_COMMAND_TYPE: begin
          cfg_r.command_type <= (cfg_wdata[1:0] == CMD_BAD) ? CMD_CC : cmd_type_t'(cfg_wdata[1:0]);
        end
        REG_COMMAND_NUMBER: cfg_r.command_number <= cfg_wdata[6:0];
        REG_SWITCH_MODE: begin
          cfg_r.switch_mode <= (cfg_wdata[2:0] > SW_SINGLE_ON) ? SW_TOGGLE_OFF
                                                               : sw_mode_t'(cfg_wdata[2:0]);
        end
        REG_MIDI_CHANNEL: cfg_r.midi_channel <= cfg_wdata[3:0];
        REG_DEBOUNCE_MS:  cfg_r.debounce_ms  <= cfg_wdata;
        REG_FLASH_MS:     cfg_r.flash_ms     <= cfg_wdata;
        default:          cfg_r              <= cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      flags_r     <= '{prev_level: 1'b1, toggle_value: 1'b0, led_level: 1'b0};
      dstamp_r    <= '0;
      fstamp_r    <= '0;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      flags_r  <= flags_nxt;
      dstamp_r <= dstamp_nxt;
      fstamp_r <= fstamp_nxt;
      if (in_ready) begin
        s1_valid_r <= in_valid;
      end
      if (out_free) begin
        out_valid_r <= s1_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_pin_r <= in_pin_level;
      s1_now_r <= in_now_ms;
    end
    if (advance) begin
      res_r <= res_step;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_led_on       = res_r.led_on;
  assign out_send_valid   = res_r.send_valid;
  assign out_message_kind = res_r.message_kind;
  assign out_status_byte  = res_r.status_byte;
  assign out_data_first   = res_r.data_first;
  assign out_data_second  = res_r.data_second;

endmodule

// ----- rtl/fmeg_step.sv -----
// Combinational step logic: one pin sample against the current switch state.
// Produces the next state and the result item; depends on fmeg_pkg.
module fmeg_step #(
  parameter int TIME_BITS = fmeg_pkg::TIME_BITS_DEF
) (
  input  fmeg_pkg::fmeg_cfg_t    cfg,
  input  logic                   pin_level,
  input  logic [TIME_BITS-1:0]   now,
  input  fmeg_pkg::fmeg_flags_t  flags,
  input  logic [TIME_BITS-1:0]   debounce_stamp,
  input  logic [TIME_BITS-1:0]   flash_stamp,
  output fmeg_pkg::fmeg_flags_t  flags_nxt,
  output logic [TIME_BITS-1:0]   debounce_stamp_nxt,
  output logic [TIME_BITS-1:0]   flash_stamp_nxt,
  output fmeg_pkg::fmeg_result_t result
);
  import fmeg_pkg::*;

  logic                 open_win;
  logic                 changed;
  logic                 press;
  logic [2:0]           sel;
  logic                 use_toggle;
  logic                 use_momentary;
  logic                 toggle_new;
  logic                 mom_high;
  logic                 fire;
  logic                 flash_expired;
  logic [TIME_BITS-1:0] fstamp_w;
  logic [1:0]           kind;
  logic [7:0]           status;
  logic [6:0]           d1;
  logic [6:0]           d2;

  assign open_win     = (now - debounce_stamp) >= TIME_BITS'(cfg.debounce_ms);
  assign changed      = pin_level != flags.prev_level;
  assign press        = !pin_level && flags.prev_level;
  // Selectors above seven fall back to play.
  assign sel          = (cfg.command_number > 7'd7) ? 3'd0 : cfg.command_number[2:0];

  always_comb begin
    use_toggle    = 1'b0;
    use_momentary = 1'b0;
    case (cfg.command_type)
      CMD_CC: begin
        use_toggle    = (cfg.switch_mode == SW_TOGGLE_OFF) || (cfg.switch_mode == SW_TOGGLE_ON);
        use_momentary = (cfg.switch_mode == SW_MOMENTARY_OFF) ||
                        (cfg.switch_mode == SW_MOMENTARY_ON);
      end
      CMD_PC:  use_toggle = 1'b0;
      default: use_toggle = mmc_is_toggle(sel);
    endcase
  end

  assign toggle_new    = !flags.toggle_value;
  assign mom_high      = press ? (cfg.switch_mode == SW_MOMENTARY_ON)
                               : (cfg.switch_mode == SW_MOMENTARY_OFF);
  assign fire          = use_momentary ? (open_win && changed) : (open_win && press);
  assign fstamp_w      = fire ? now : flash_stamp;
  assign flash_expired = (now - fstamp_w) > TIME_BITS'(cfg.flash_ms);

  // Message fields for the active path, taken only when the edge fires.
  always_comb begin
    kind   = KIND_CC;
    status = CC_STATUS | {4'h0, cfg.midi_channel};
    d1     = cfg.command_number;
    d2     = 7'd0;
    case (cfg.command_type)
      CMD_CC: begin
        if (use_toggle) begin
          d2 = toggle_new ? CC_FULL : 7'd0;
        end else if (use_momentary) begin
          d2 = mom_high ? CC_FULL : 7'd0;
        end else begin
          d2 = (cfg.switch_mode == SW_SINGLE_ON) ? CC_FULL : 7'd0;
        end
      end
      CMD_PC: begin
        kind   = KIND_PC;
        status = PC_STATUS | {4'h0, cfg.midi_channel};
      end
      default: begin
        kind   = KIND_MMC;
        status = 8'h00;
        d1     = (use_toggle && !toggle_new) ? mmc_off_code(sel) : mmc_on_code(sel);
      end
    endcase
  end

  always_comb begin
    flags_nxt            = flags;
    flags_nxt.prev_level = pin_level;
    debounce_stamp_nxt   = (open_win && changed) ? now : debounce_stamp;
    flash_stamp_nxt      = flash_stamp;
    if (use_toggle) begin
      if (fire) begin
        flags_nxt.toggle_value = toggle_new;
        flags_nxt.led_level    = toggle_new;
      end
    end else if (use_momentary) begin
      if (fire) begin
        flags_nxt.led_level = mom_high;
      end
    end else begin
      flash_stamp_nxt = fstamp_w;
      if (flash_expired) begin
        flags_nxt.led_level = 1'b0;
      end else if (fire) begin
        flags_nxt.led_level = 1'b1;
      end
    end
  end

  always_comb begin
    result              = '0;
    result.led_on       = flags_nxt.led_level;
    result.send_valid   = fire;
    if (fire) begin
      result.message_kind = kind;
      result.status_byte  = status;
      result.data_first   = d1;
      result.data_second  = d2;
    end
  end

endmodule

// ----- rtl/fmeg_checker.sv -----
// Port-level checker for the footswitch MIDI event generator, bound to the top level.
// Depends on fmeg_pkg for the message kinds and status constants.
module fmeg_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic       out_led_on,
  input logic       out_send_valid,
  input logic [1:0] out_message_kind,
  input logic [7:0] out_status_byte,
  input logic [6:0] out_data_first,
  input logic [6:0] out_data_second
);
  import fmeg_pkg::*;

  // A stalled result keeps its payload until its transfer.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_led_on) &&
      $stable(out_send_valid) && $stable(out_message_kind) && $stable(out_status_byte) &&
      $stable(out_data_first) && $stable(out_data_second))
    else $error("result changed while stalled");

  // The input side only stalls when the result register is full and blocked.
  a_in_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid && !out_ready)
    else $error("input stalled without a blocked result");

  a_no_msg_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_send_valid |-> out_message_kind == 2'd0 && out_status_byte == 8'd0 &&
      out_data_first == 7'd0 && out_data_second == 7'd0)
    else $error("message fields set without a message");

  a_kind_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_send_valid |->
      (out_message_kind == KIND_CC && out_status_byte[7:4] == CC_STATUS[7:4]) ||
      (out_message_kind == KIND_PC && out_status_byte[7:4] == PC_STATUS[7:4] &&
       out_data_second == 7'd0) ||
      (out_message_kind == KIND_MMC && out_status_byte == 8'd0 && out_data_second == 7'd0))
    else $error("message kind does not match its status byte");

endmodule

bind footswitch_midi_event_generator fmeg_checker u_fmeg_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_ready         (in_ready),
  .out_valid        (out_valid),
  .out_ready        (out_ready),
  .out_led_on       (out_led_on),
  .out_send_valid   (out_send_valid),
  .out_message_kind (out_message_kind),
  .out_status_byte  (out_status_byte),
  .out_data_first   (out_data_first),
  .out_data_second  (out_data_second)
);
